FILE: hdl/grd_pkg.sv
// Shared types and constants for the gyro rate deadband integrator.
// Used by every module in this folder; depends on nothing else.
package grd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int GAIN_W   = 32;
  localparam int PROD_W   = GAIN_W + DIFF_W;
  localparam int RATE_W   = 32;
  localparam int TIME_W   = 48;
  localparam int HALF_W   = TIME_W / 2;
  localparam int PP_W     = RATE_W + HALF_W + 1;
  localparam int ANGLE_W  = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B   = 8'd3;

  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 16'd32768;

  localparam logic signed [PROD_W-1:0] ONE_DPS  = 49'sd65536;
  localparam logic signed [PROD_W-1:0] RATE_MAX = 49'sd2147483647;
  localparam logic signed [PROD_W-1:0] RATE_MIN = -49'sd2147483648;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DEC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic                     in_band;
    logic signed [RATE_W-1:0] rate_sat;
  } lane_stat_t;

  typedef struct packed {
    logic mul_lo;
    logic mul_hi;
    logic commit;
  } int_ctl_t;

endpackage

FILE: hdl/grd_rate_lane.sv
// One channel lane: offset removal, gain multiply, deadband test and saturation.
// Depends on grd_pkg.
module grd_rate_lane (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [grd_pkg::SAMPLE_W-1:0]          sample,
  input  logic [grd_pkg::SAMPLE_W-1:0]          offset,
  input  logic signed [grd_pkg::GAIN_W-1:0]     gain,
  output grd_pkg::lane_stat_t                   stat
);

  logic signed [grd_pkg::DIFF_W-1:0] diff;
  logic signed [grd_pkg::PROD_W-1:0] prod;

  always_comb begin
    diff = $signed({1'b0, sample}) - $signed({1'b0, offset});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= gain * diff;
    end
  end

  always_comb begin
    stat.in_band = (prod < grd_pkg::ONE_DPS) && (prod > -grd_pkg::ONE_DPS);
    if (prod > grd_pkg::RATE_MAX) begin
      stat.rate_sat = grd_pkg::RATE_MAX[grd_pkg::RATE_W-1:0];
    end else if (prod < grd_pkg::RATE_MIN) begin
      stat.rate_sat = grd_pkg::RATE_MIN[grd_pkg::RATE_W-1:0];
    end else begin
      stat.rate_sat = prod[grd_pkg::RATE_W-1:0];
    end
  end

endmodule

FILE: hdl/grd_merge.sv
// Combines the deadband results of both lanes and keeps the re-arm flag.
// Depends on grd_pkg.
module grd_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  grd_pkg::lane_stat_t                  stat_a,
  input  grd_pkg::lane_stat_t                  stat_b,
  output logic signed [grd_pkg::RATE_W-1:0]    rate_a,
  output logic signed [grd_pkg::RATE_W-1:0]    rate_b
);

  logic rearm;
  logic any_band;

  assign any_band = stat_a.in_band || stat_b.in_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      rearm <= 1'b1;
    end else if (en) begin
      if (any_band) begin
        rearm <= 1'b1;
      end else if (rearm) begin
        rearm <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (any_band || rearm) begin
        rate_a <= '0;
        rate_b <= '0;
      end else begin
        rate_a <= stat_a.rate_sat;
        rate_b <= stat_b.rate_sat;
      end
    end
  end

endmodule

FILE: hdl/grd_integ_lane.sv
// One channel integrator: rate times time step in two partial products, then accumulate.
// Depends on grd_pkg.
module grd_integ_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  grd_pkg::int_ctl_t                     ctl,
  input  logic signed [grd_pkg::RATE_W-1:0]     rate,
  input  logic [grd_pkg::TIME_W-1:0]            dt,
  output logic [grd_pkg::ANGLE_W-1:0]           angle_next
);

  logic signed [grd_pkg::HALF_W:0]    mul_b;
  logic signed [grd_pkg::PP_W-1:0]    prod;
  logic signed [grd_pkg::PP_W-1:0]    pp;
  logic [grd_pkg::ANGLE_W-1:0]        sum;
  logic [grd_pkg::ANGLE_W-1:0]        acc;

  always_comb begin
    if (ctl.mul_hi) begin
      mul_b = $signed({dt[grd_pkg::TIME_W-1], dt[grd_pkg::TIME_W-1:grd_pkg::HALF_W]});
    end else begin
      mul_b = $signed({1'b0, dt[grd_pkg::HALF_W-1:0]});
    end
    prod = rate * mul_b;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_lo || ctl.mul_hi) begin
      pp <= prod;
    end
    if (ctl.mul_hi) begin
      sum <= acc + {{(grd_pkg::ANGLE_W - grd_pkg::PP_W){pp[grd_pkg::PP_W-1]}}, pp};
    end
  end

  assign angle_next = sum +
    {pp[grd_pkg::ANGLE_W-grd_pkg::HALF_W-1:0], {grd_pkg::HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.commit) begin
      acc <= angle_next;
    end
  end

endmodule

FILE: hdl/gyro_rate_deadband_integrator_core.sv
// Top level of the two-channel gyro rate integrator with deadband.
// Depends on grd_pkg, grd_rate_lane, grd_merge and grd_integ_lane.
//
// Usage:
// The input channel (in_valid, in_stall) carries a timestamp and one ADC code
// per channel. The output channel (out_valid, out_stall) returns both rates
// after the deadband and both accumulated angles, one result per input.
// A transfer happens at a clock edge where valid is high and stall is low.
// Configuration registers are written through cfg_valid, cfg_ready, cfg_index
// and cfg_data; cfg_ready is always high and indexes beyond three are ignored.
// Each item passes in turn through capture, the gain multiply in both lanes,
// the deadband merge and the integration, where each lane reuses one 32 by
// 25 bit multiplier for the two halves of the time step before the
// accumulator update. The result is written to the output register at the
// accumulator update, and a new item is taken in the cycle after that.
// The output register lets the next item be taken while a result waits; if
// the receiver keeps stalling, the block holds at the accumulator update.
// Reset restores the default offsets and gains, clears the angles, arms the
// first-sample and re-arm flags, and empties the output register.
module gyro_rate_deadband_integrator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [grd_pkg::TIME_W-1:0]            timestamp,
  input  logic [grd_pkg::SAMPLE_W-1:0]          sample_a,
  input  logic [grd_pkg::SAMPLE_W-1:0]          sample_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [grd_pkg::RATE_W-1:0]     rate_a,
  output logic signed [grd_pkg::RATE_W-1:0]     rate_b,
  output logic signed [grd_pkg::ANGLE_W-1:0]    angle_a,
  output logic signed [grd_pkg::ANGLE_W-1:0]    angle_b,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [grd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [grd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  grd_pkg::state_t state, state_next;

  logic [grd_pkg::SAMPLE_W-1:0]          offset_a, offset_b;
  logic signed [grd_pkg::GAIN_W-1:0]     gain_a, gain_b;
  logic [grd_pkg::TIME_W-1:0]            ts_in;
  logic [grd_pkg::SAMPLE_W-1:0]          samp_a_in, samp_b_in;
  logic [grd_pkg::TIME_W-1:0]            last_time;
  logic                                  first_sample;
  logic [grd_pkg::TIME_W-1:0]            dt;

  logic                                  in_xfer;
  logic                                  out_free;
  logic                                  lane_en;
  logic                                  merge_en;
  grd_pkg::int_ctl_t                     ctl;
  grd_pkg::lane_stat_t                   stat_a, stat_b;
  logic signed [grd_pkg::RATE_W-1:0]     mrate_a, mrate_b;
  logic [grd_pkg::ANGLE_W-1:0]           next_a, next_b;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_a <= grd_pkg::OFFSET_RESET;
      gain_a   <= '0;
      offset_b <= grd_pkg::OFFSET_RESET;
      gain_b   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        grd_pkg::CFG_OFFSET_A: begin
          offset_a <= cfg_data[grd_pkg::SAMPLE_W-1:0];
        end
        grd_pkg::CFG_GAIN_A: begin
          gain_a <= $signed(cfg_data[grd_pkg::GAIN_W-1:0]);
        end
        grd_pkg::CFG_OFFSET_B: begin
          offset_b <= cfg_data[grd_pkg::SAMPLE_W-1:0];
        end
        grd_pkg::CFG_GAIN_B: begin
          gain_b <= $signed(cfg_data[grd_pkg::GAIN_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    lane_en    = 1'b0;
    merge_en   = 1'b0;
    ctl        = '0;
    case (state)
      grd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = grd_pkg::ST_PROD;
        end
      end
      grd_pkg::ST_PROD: begin
        lane_en    = 1'b1;
        state_next = grd_pkg::ST_DEC;
      end
      grd_pkg::ST_DEC: begin
        merge_en   = 1'b1;
        state_next = grd_pkg::ST_MUL_LO;
      end
      grd_pkg::ST_MUL_LO: begin
        ctl.mul_lo = 1'b1;
        state_next = grd_pkg::ST_MUL_HI;
      end
      grd_pkg::ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_next = grd_pkg::ST_COMMIT;
      end
      grd_pkg::ST_COMMIT: begin
        ctl.commit = out_free;
        if (out_free) begin
          state_next = grd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = grd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ts_in     <= timestamp;
      samp_a_in <= sample_a;
      samp_b_in <= sample_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample <= 1'b1;
      last_time    <= '0;
    end else if (lane_en) begin
      first_sample <= 1'b0;
      last_time    <= ts_in;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_en) begin
      if (first_sample) begin
        dt <= '0;
      end else begin
        dt <= ts_in - last_time;
      end
    end
  end

  grd_rate_lane u_lane_a (
    .clk    (clk),
    .en     (lane_en),
    .sample (samp_a_in),
    .offset (offset_a),
    .gain   (gain_a),
    .stat   (stat_a)
  );

  grd_rate_lane u_lane_b (
    .clk    (clk),
    .en     (lane_en),
    .sample (samp_b_in),
    .offset (offset_b),
    .gain   (gain_b),
    .stat   (stat_b)
  );

  grd_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .en     (merge_en),
    .stat_a (stat_a),
    .stat_b (stat_b),
    .rate_a (mrate_a),
    .rate_b (mrate_b)
  );

  grd_integ_lane u_integ_a (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rate       (mrate_a),
    .dt         (dt),
    .angle_next (next_a)
  );

  grd_integ_lane u_integ_b (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rate       (mrate_b),
    .dt         (dt),
    .angle_next (next_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rate_a  <= mrate_a;
      rate_b  <= mrate_b;
      angle_a <= $signed(next_a);
      angle_b <= $signed(next_b);
    end
  end

endmodule
